@@ sv/apr_pkg.sv @@
// apr_pkg: constants, codes and transfer types of the audio packet reassembly block.
// No dependencies; used by the channel interfaces and the top level.
package apr_pkg;

	localparam int CHANNELS      = 2;
	localparam int MAX_CHUNK     = 128;
	localparam int MAX_FRAGMENTS = 32;
	localparam int BUF_LEN       = MAX_FRAGMENTS * MAX_CHUNK;
	localparam int DEPTH         = CHANNELS * BUF_LEN;
	localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOTAL_W       = $clog2(MAX_FRAGMENTS + 1);
	localparam int CNT_W         = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLES     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAMING_MODE  = 2'd3;

	localparam logic FUNC_BEAT = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [1:0] ST_NOT_READY = 2'd0;
	localparam logic [1:0] ST_COMPLETE  = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	typedef struct packed {
		logic        func;
		logic [31:0] seq;
		logic [7:0]  frag_idx;
		logic [7:0]  frag_cnt;
		logic [7:0]  frag_len;
		logic [3:0]  channel;
		logic [11:0] position;
		logic [31:0] sample;
		logic        last;
	} req_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] sample_count;
		logic [31:0]      read_data;
		logic             read_valid;
	} rsp_item_t;

endpackage

@@ sv/apr_req_if.sv @@
// apr_req_if: valid/ready channel carrying fragment beats and read requests.
// Depends on apr_pkg for the payload type.
interface apr_req_if;
	logic              valid;
	logic              ready;
	apr_pkg::req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/apr_rsp_if.sv @@
// apr_rsp_if: valid/ready channel carrying status and read results.
// Depends on apr_pkg for the payload type.
interface apr_rsp_if;
	logic              valid;
	logic              ready;
	apr_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/audio_packet_reassembly.sv @@
// audio_packet_reassembly: fragment reassembly into a sample store with a received bitmap.
// Depends on apr_pkg, apr_req_if and apr_rsp_if.
//
// Usage:
//   req carries one transfer per sample beat (func 0) or per read (func 1).
//   rsp carries one transfer per last beat (status, sample_count) and per read
//   (read_data, read_valid); other beats give no transfer.
//   cfg_we/cfg_index/cfg_data write the four registers; write only while idle.
// Throughput: one req transfer per cycle unless stalled. Each beat does its header
//   checks, bitmap update and single store write in the cycle it is taken.
// Path: a result goes from the registered store read stage to the output register,
//   and is driven onto rsp from there.
// Stall: while rsp is held off, one result waits in the output register and
//   one in the store read stage; req.ready drops only when both are full.
// Reset: registers return to their defaults, the sequence to all ones, the
//   bitmap, fragment total and ready count to zero. The store is not cleared;
//   no reset pass is needed, and reads are gated by the ready count.
module audio_packet_reassembly (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [apr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apr_pkg::CFG_DATA_W-1:0]  cfg_data,
	apr_req_if.sink                         req,
	apr_rsp_if.source                       rsp
);

	logic [4:0]  channels_in_use_q;
	logic [4:0]  out_channels_q;
	logic [12:0] max_samples_q;
	logic        streaming_mode_q;

	logic [31:0]                       cur_seq_q;
	logic [apr_pkg::MAX_FRAGMENTS-1:0] map_q;
	logic [apr_pkg::TOTAL_W-1:0]       total_q;
	logic [apr_pkg::CNT_W-1:0]         ready_cnt_q;

	logic [31:0] store_mem [apr_pkg::DEPTH];
	logic [31:0] rd_q;

	logic                      v_s1;
	logic [1:0]                status_s1;
	logic [apr_pkg::CNT_W-1:0] count_s1;
	logic                      rvalid_s1;

	logic               out_v_q;
	apr_pkg::rsp_item_t out_q;

	apr_pkg::req_item_t d;
	logic        advance, acc, is_read, is_beat;
	logic [31:0] off;
	logic        hit, bad, too_long, ok, newseq, dup, in_range, wr_en, take_frag, complete;
	logic [7:0]  idx_eff;
	logic [31:0] seq_eff;
	logic [apr_pkg::MAX_FRAGMENTS-1:0] map_eff, map_new;
	logic [apr_pkg::TOTAL_W-1:0]       total_eff, total_new;
	logic [apr_pkg::CNT_W-1:0]         rc_eff, cnt_cap;
	logic [16:0] frag_addr;
	logic [15:0] span;
	logic [apr_pkg::ADDR_W-1:0] waddr, raddr;
	logic        rd_ok, has_result;
	logic [1:0]  status_new;

	assign d       = req.data;
	assign advance = !out_v_q || rsp.ready;
	assign req.ready = !v_s1 || advance;
	assign acc     = req.valid && req.ready;
	assign is_read = d.func == apr_pkg::FUNC_READ;
	assign is_beat = d.func == apr_pkg::FUNC_BEAT;

	always_comb begin
		off      = d.seq - cur_seq_q;
		hit      = streaming_mode_q && (off < {24'd0, d.frag_cnt});
		idx_eff  = hit ? off[7:0] : d.frag_idx;
		seq_eff  = hit ? cur_seq_q : d.seq;
		bad      = (d.frag_cnt == 8'd0) || (32'(d.frag_cnt) > apr_pkg::MAX_FRAGMENTS)
		           || (idx_eff >= d.frag_cnt);
		too_long = 32'(d.frag_len) > apr_pkg::MAX_CHUNK;
		ok       = is_beat && !bad && !too_long;
		newseq   = seq_eff != cur_seq_q;
		map_eff  = newseq ? '0 : map_q;
		total_eff = newseq ? '0 : total_q;
		rc_eff   = newseq ? '0 : ready_cnt_q;
		dup      = map_eff[idx_eff[$clog2(apr_pkg::MAX_FRAGMENTS)-1:0]];
		frag_addr = 17'(idx_eff) * 17'(d.frag_len) + 17'(d.position);
		in_range = ({1'b0, d.channel} < channels_in_use_q)
		           && (32'(d.channel) < apr_pkg::CHANNELS)
		           && ({4'd0, d.position} < {8'd0, d.frag_len})
		           && (frag_addr < 17'(apr_pkg::BUF_LEN));
		wr_en    = acc && ok && !dup && in_range;
		waddr    = apr_pkg::ADDR_W'(32'(d.channel) * apr_pkg::BUF_LEN + 32'(frag_addr));
		raddr    = apr_pkg::ADDR_W'(32'(d.channel) * apr_pkg::BUF_LEN + 32'(d.position));
		take_frag = ok && !dup && d.last;
		map_new  = map_eff | (take_frag ? (apr_pkg::MAX_FRAGMENTS'(1) << idx_eff) : '0);
		total_new = total_eff + (take_frag ? apr_pkg::TOTAL_W'(1) : '0);
		span     = 16'(d.frag_cnt) * 16'(d.frag_len);
		cnt_cap  = (span < {3'd0, max_samples_q}) ? apr_pkg::CNT_W'(span) : max_samples_q;
		complete = ok && d.last && (32'(total_new) == 32'(d.frag_cnt));
		rd_ok    = ({1'b0, d.channel} < out_channels_q) && ({1'b0, d.channel} < channels_in_use_q)
		           && (32'(d.channel) < apr_pkg::CHANNELS) && ({1'b0, d.position} < ready_cnt_q)
		           && (32'(d.position) < apr_pkg::BUF_LEN);
		has_result = is_read || d.last;
		if (bad)
			status_new = apr_pkg::ST_BAD_INDEX;
		else if (too_long)
			status_new = apr_pkg::ST_TOO_LONG;
		else if (complete)
			status_new = apr_pkg::ST_COMPLETE;
		else
			status_new = apr_pkg::ST_NOT_READY;
		if (is_read)
			status_new = apr_pkg::ST_NOT_READY;
	end

	// configuration and reassembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_in_use_q <= 5'd2;
			out_channels_q    <= 5'd2;
			max_samples_q     <= 13'd4096;
			streaming_mode_q  <= 1'b0;
			cur_seq_q         <= '1;
			map_q             <= '0;
			total_q           <= '0;
			ready_cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					apr_pkg::CFG_CHANNELS_IN_USE: channels_in_use_q <= cfg_data[4:0];
					apr_pkg::CFG_OUT_CHANNELS:    out_channels_q    <= cfg_data[4:0];
					apr_pkg::CFG_MAX_SAMPLES:     max_samples_q     <= cfg_data[12:0];
					apr_pkg::CFG_STREAMING_MODE:  streaming_mode_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (acc && ok) begin
				cur_seq_q   <= seq_eff;
				map_q       <= map_new;
				total_q     <= total_new;
				ready_cnt_q <= complete ? cnt_cap : rc_eff;
			end
		end
	end

	// sample store: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			store_mem[waddr] <= d.sample;
		if (acc && is_read)
			rd_q <= store_mem[raddr];
	end

	// store read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc)
				v_s1 <= has_result;
			else if (advance)
				v_s1 <= 1'b0;
			if (advance)
				out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_new;
			count_s1  <= (!is_read && complete) ? cnt_cap : '0;
			rvalid_s1 <= is_read && rd_ok;
		end
		if (advance && v_s1) begin
			out_q.status       <= status_s1;
			out_q.sample_count <= count_s1;
			out_q.read_data    <= rvalid_s1 ? rd_q : 32'd0;
			out_q.read_valid   <= rvalid_s1;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	a_total_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) == $countones(map_q))
		else $error("fragment total disagrees with bitmap");

	a_complete_capped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == apr_pkg::ST_COMPLETE
		|-> rsp.data.sample_count <= max_samples_q)
		else $error("complete count above cap");

	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.read_valid
		|-> rsp.data.status == apr_pkg::ST_NOT_READY && rsp.data.sample_count == '0)
		else $error("read result with beat status");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !advance |=> v_s1)
		else $error("pending result dropped under stall");

endmodule

@@ test/tb.sv @@
// tb: self-checking bench for audio_packet_reassembly, driving fragment beats and reads
// through apr_req_if and checking every transfer on apr_rsp_if against a mirror of the block.
// Depends on apr_pkg, apr_req_if, apr_rsp_if and the audio_packet_reassembly RTL.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 4;
	localparam int PHASES      = 7;
	localparam int QUOTA       = 270;

	class reassembly_mirror;
		logic [4:0]                ch_in_use;
		logic [4:0]                out_ch;
		logic [12:0]               max_smp;
		logic                      stream;
		logic [31:0]               cur_seq;
		logic [31:0]               rx_map;
		logic [5:0]                rx_total;
		logic [apr_pkg::CNT_W-1:0] ready_cnt;
		logic [31:0]               store [apr_pkg::DEPTH];
		bit                        written [apr_pkg::DEPTH];
		apr_pkg::rsp_item_t        due [$];
		int                        errors;
		int                        n_beats;
		int                        n_reads;
		int                        n_complete;
		int                        n_checked;

		function new();
			ch_in_use  = 5'd2;
			out_ch     = 5'd2;
			max_smp    = 13'd4096;
			stream     = 1'b0;
			cur_seq    = '1;
			rx_map     = '0;
			rx_total   = '0;
			ready_cnt  = '0;
			errors     = 0;
			n_beats    = 0;
			n_reads    = 0;
			n_complete = 0;
			n_checked  = 0;
		endfunction

		function void configure(input logic [apr_pkg::CFG_IDX_W-1:0] idx,
			input logic [apr_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				apr_pkg::CFG_CHANNELS_IN_USE: ch_in_use = val[4:0];
				apr_pkg::CFG_OUT_CHANNELS:    out_ch    = val[4:0];
				apr_pkg::CFG_MAX_SAMPLES:     max_smp   = val[12:0];
				apr_pkg::CFG_STREAMING_MODE:  stream    = val[0];
				default: ;
			endcase
		endfunction

		function bit blank_read(input logic [3:0] ch, input logic [11:0] pos);
			if (ch < out_ch && ch < ch_in_use && ch < apr_pkg::CHANNELS && pos < ready_cnt)
				return !written[int'(ch) * apr_pkg::BUF_LEN + int'(pos)];
			return 1'b0;
		endfunction

		function void absorb(input apr_pkg::req_item_t it);
			logic [31:0]        seq;
			logic [31:0]        off;
			logic [7:0]         idx;
			int                 addr;
			int                 total;
			apr_pkg::rsp_item_t r;
			bit                 emit;
			r = '0;
			emit = 1'b0;
			if (it.func == apr_pkg::FUNC_READ) begin
				n_reads++;
				emit = 1'b1;
				if (it.channel < out_ch && it.channel < ch_in_use &&
				    it.channel < apr_pkg::CHANNELS && it.position < ready_cnt) begin
					r.read_valid = 1'b1;
					r.read_data  = store[int'(it.channel) * apr_pkg::BUF_LEN + int'(it.position)];
				end
			end else begin
				n_beats++;
				seq = it.seq;
				idx = it.frag_idx;
				if (stream) begin
					off = seq - cur_seq;
					if (off < it.frag_cnt) begin
						idx = off[7:0];
						seq = cur_seq;
					end
				end
				if (it.frag_cnt == 0 || it.frag_cnt > apr_pkg::MAX_FRAGMENTS ||
				    idx >= it.frag_cnt) begin
					emit = it.last;
					r.status = apr_pkg::ST_BAD_INDEX;
				end else if (it.frag_len > apr_pkg::MAX_CHUNK) begin
					emit = it.last;
					r.status = apr_pkg::ST_TOO_LONG;
				end else begin
					if (seq != cur_seq) begin
						cur_seq   = seq;
						rx_map    = '0;
						rx_total  = '0;
						ready_cnt = '0;
					end
					if (!rx_map[idx]) begin
						if (it.channel < ch_in_use && it.channel < apr_pkg::CHANNELS &&
						    it.position < it.frag_len) begin
							addr = int'(idx) * int'(it.frag_len) + int'(it.position);
							if (addr < apr_pkg::BUF_LEN) begin
								store[int'(it.channel) * apr_pkg::BUF_LEN + addr]   = it.sample;
								written[int'(it.channel) * apr_pkg::BUF_LEN + addr] = 1'b1;
							end
						end
						if (it.last) begin
							rx_map[idx] = 1'b1;
							rx_total    = rx_total + 6'd1;
						end
					end
					if (it.last) begin
						emit = 1'b1;
						if (rx_total == it.frag_cnt) begin
							total     = int'(it.frag_cnt) * int'(it.frag_len);
							ready_cnt = (total < max_smp) ? total[12:0] : max_smp;
							r.status       = apr_pkg::ST_COMPLETE;
							r.sample_count = ready_cnt;
							n_complete++;
						end else begin
							r.status = apr_pkg::ST_NOT_READY;
						end
					end
				end
			end
			if (emit)
				due.push_back(r);
		endfunction

		task flag(input string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		task compare(input apr_pkg::rsp_item_t got);
			apr_pkg::rsp_item_t want;
			n_checked++;
			if (due.size() == 0) begin
				flag($sformatf("result %0d arrived with nothing expected", n_checked));
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status)
				flag($sformatf("result %0d status %0d, expected %0d",
					n_checked, got.status, want.status));
			if (got.sample_count !== want.sample_count)
				flag($sformatf("result %0d sample_count %0d, expected %0d",
					n_checked, got.sample_count, want.sample_count));
			if (got.read_data !== want.read_data)
				flag($sformatf("result %0d read_data %h, expected %h",
					n_checked, got.read_data, want.read_data));
			if (got.read_valid !== want.read_valid)
				flag($sformatf("result %0d read_valid %b, expected %b",
					n_checked, got.read_valid, want.read_valid));
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [apr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [apr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           hold;
	logic                           squeeze;
	bit                             req_calm;
	bit                             req_burst;
	bit                             rsp_calm;
	int                             sent;
	int                             settings;
	int                             cycles;

	reassembly_mirror sb = new();

	apr_req_if req_ch();
	apr_rsp_if rsp_ch();

	audio_packet_reassembly uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic apr_pkg::req_item_t beat(input logic [31:0] seq,
		input int idx, npk, ns, ch, pos, input logic last, input logic [31:0] smp);
		apr_pkg::req_item_t it;
		it.func         = apr_pkg::FUNC_BEAT;
		it.seq          = seq;
		it.frag_idx     = 8'(idx);
		it.frag_cnt     = 8'(npk);
		it.frag_len     = 8'(ns);
		it.channel      = 4'(ch);
		it.position     = 12'(pos);
		it.sample       = smp;
		it.last         = last;
		return it;
	endfunction

	function automatic apr_pkg::req_item_t read_at(input int ch, pos);
		apr_pkg::req_item_t it;
		it = beat($urandom, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			ch, pos, 1'($urandom_range(0, 1)), $urandom);
		it.func = apr_pkg::FUNC_READ;
		return it;
	endfunction

	// reads, aimed at assembled data if aimed is set; never lands on a store entry that was not written
	function automatic apr_pkg::req_item_t read_item(input bit aimed);
		apr_pkg::req_item_t it;
		int k;
		it = read_at($urandom_range(0, 15), $urandom_range(0, 4095));
		for (k = 0; aimed && k < 4; k++) begin
			it.channel = 4'($urandom_range(0, apr_pkg::CHANNELS));
			if (sb.ready_cnt != 0 && $urandom_range(0, 7) != 0)
				it.position = 12'($urandom_range(0, sb.ready_cnt - 1));
			else
				it.position = 12'($urandom_range(0, 4095));
			if (!sb.blank_read(it.channel, it.position))
				k = 4;
		end
		if (sb.blank_read(it.channel, it.position))
			it.channel = 4'hF;
		return it;
	endfunction

	task automatic send(input apr_pkg::req_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			req_calm = !req_calm;
		gap = (req_calm || req_burst) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.data  <= it;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.absorb(it);
		sent++;
	endtask

	task automatic send_fragment(input logic [31:0] seq, input int idx, npk, ns, nch,
		input bit sparse);
		int p;
		int c;
		int lim;
		bit fin;
		lim = (ns > 0) ? ns : 1;
		for (p = 0; p < lim; p++) begin
			for (c = 0; c < nch; c++) begin
				fin = (p == lim - 1) && (c == nch - 1);
				if (!sparse || fin || $urandom_range(0, 31) == 0)
					send(beat(seq, idx, npk, ns, c, p, fin, $urandom));
			end
		end
	endtask

	// flaw: 0 clean, 1 one fragment dropped (only if there is more than one), 2 one fragment sent twice
	task automatic send_buffer(input int npk, ns, nch, input bit sparse, input int flaw);
		int          order [32];
		int          j;
		int          t;
		int          k;
		int          lo;
		int          skip;
		int          twice;
		bit          streamed;
		logic [31:0] seq0;
		logic [31:0] fseq;
		int          fidx;
		streamed = sb.stream && ($urandom_range(0, 3) != 0);
		lo = streamed ? 1 : 0;
		for (k = 0; k < npk; k++)
			order[k] = k;
		for (k = npk - 1; k > lo; k--) begin
			j = $urandom_range(lo, k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		seq0 = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
		skip  = (flaw == 1 && npk > 1) ? $urandom_range(lo, npk - 1) : -1;
		twice = (flaw == 2) ? $urandom_range(0, npk - 1) : -1;
		for (k = 0; k < npk; k++) begin
			if (k == skip)
				continue;
			fseq = streamed ? seq0 + order[k] : seq0;
			fidx = streamed ? ((k == 0) ? 0 : $urandom_range(0, 255)) : order[k];
			send_fragment(fseq, fidx, npk, ns, nch, sparse);
			if (k == twice)
				send_fragment(fseq, fidx, npk, ns, nch, sparse);
		end
		repeat ($urandom_range(1, 6)) send(read_item(1'b1));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [apr_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= apr_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		sb.configure(idx, apr_pkg::CFG_DATA_W'(val));
	endtask

	task automatic apply_settings(input int cin, cout, cmax, cstr);
		write_reg(apr_pkg::CFG_CHANNELS_IN_USE, cin);
		write_reg(apr_pkg::CFG_OUT_CHANNELS, cout);
		write_reg(apr_pkg::CFG_MAX_SAMPLES, cmax);
		write_reg(apr_pkg::CFG_STREAMING_MODE, cstr);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic random_phase(input int quota);
		int stop;
		int pick;
		int nch;
		stop = sent + quota;
		while (sent < stop) begin
			pick = $urandom_range(0, 99);
			nch = (sb.ch_in_use < apr_pkg::CHANNELS) ? int'(sb.ch_in_use) : apr_pkg::CHANNELS;
			if (pick < 55) begin
				send_buffer($urandom_range(1, 6), $urandom_range(1, 8), nch, 1'b0, 0);
			end else if (pick < 62) begin
				case ($urandom_range(0, 2))
					0: send_buffer(apr_pkg::MAX_FRAGMENTS, $urandom_range(1, 2), 1, 1'b0, 0);
					1: send_buffer(1, $urandom_range(100, apr_pkg::MAX_CHUNK), 1, 1'b0, 0);
					default: send_buffer(apr_pkg::MAX_FRAGMENTS, apr_pkg::MAX_CHUNK, 1, 1'b1, 0);
				endcase
			end else if (pick < 72) begin
				send_buffer($urandom_range(1, 5), $urandom_range(1, 6), nch,
					1'($urandom_range(0, 1)), $urandom_range(1, 2));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 8)) send(read_item($urandom_range(0, 3) != 0));
			end else begin
				repeat ($urandom_range(1, 4))
					send(beat($urandom_range(0, 1) ? sb.cur_seq : $urandom,
						($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 7)),
						($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 8)),
						($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8)),
						$urandom_range(0, 15),
						($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 9)),
						1'($urandom_range(0, 1)), $urandom));
			end
		end
	endtask

	initial begin : rsp_side
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rsp_calm = !rsp_calm;
			gap = rsp_calm ? 0 : $urandom_range(0, 11);
			if (gap > 0 || hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			sb.compare(rsp_ch.data);
		end
	end

	// long hold-off on rsp while reads keep coming, so req.ready has to drop
	initial begin : squeeze_side
		hold = 1'b0;
		wait (squeeze);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	initial begin : stimulus
		int ph;
		sent         = 0;
		settings     = 0;
		squeeze      = 1'b0;
		req_calm     = 1'b0;
		req_burst    = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header errors, a small buffer out of order, duplicate, reads, new sequence
		send(read_at(0, 0));
		send(beat(32'd7, 0, 0, 4, 0, 0, 1'b1, $urandom));
		send(beat(32'd7, 0, apr_pkg::MAX_FRAGMENTS + 1, 4, 0, 0, 1'b1, $urandom));
		send(beat(32'd7, 0, 255, 4, 0, 0, 1'b1, $urandom));
		send(beat(32'd7, 4, 4, 4, 0, 0, 1'b1, $urandom));
		send(beat(32'd7, 0, 4, apr_pkg::MAX_CHUNK + 1, 0, 0, 1'b1, $urandom));
		send(beat(32'd7, 0, 4, 255, 0, 0, 1'b1, $urandom));
		send(beat(32'd7, 9, 4, 4, 0, 0, 1'b0, $urandom));
		send(beat(32'd0, 1, 2, 2, 0, 0, 1'b0, 32'h0000_0000));
		send(beat(32'd0, 1, 2, 2, 1, 0, 1'b0, $urandom));
		send(beat(32'd0, 1, 2, 2, 0, 1, 1'b0, $urandom));
		send(beat(32'd0, 1, 2, 2, 1, 1, 1'b1, $urandom));
		send_fragment(32'd0, 0, 2, 2, 2, 1'b0);
		send(beat(32'd0, 0, 2, 2, 0, 0, 1'b1, $urandom));
		send(read_at(0, 3));
		send(read_at(1, 0));
		send(read_at(1, 4));
		send(read_at(15, 0));
		send(beat(32'hFFFF_FFFF, 0, 1, 1, 0, 0, 1'b1, 32'hFFFF_FFFF));
		send(read_at(0, 0));
		send(read_at(0, 1));
		send(beat(32'd5, 0, 1, 0, 0, 0, 1'b1, $urandom));
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_settings(2, 2, 4096, 0);
				1: apply_settings(1, 16, 4096, 0);
				2: apply_settings(16, 2, 0, 1);
				3: apply_settings(2, 1, 4095, 1);
				4: apply_settings(15, 0, $urandom_range(1, 4096), 0);
				5: apply_settings(2, 2, $urandom_range(1, 40), 1);
				default: apply_settings($urandom_range(1, 16), $urandom_range(0, 16),
					$urandom_range(0, 4096), $urandom_range(0, 1));
			endcase
			if (ph == 1) begin
				send_buffer(3, 4, 1, 1'b0, 0);
				squeeze   = 1'b1;
				req_burst = 1'b1;
				repeat (60) send(read_item(1'b1));
				req_burst = 1'b0;
			end
			random_phase(QUOTA);
			drain();
		end
		repeat (10) @(posedge clk);
		if (sb.due.size() != 0)
			sb.flag($sformatf("%0d results still expected at the end", sb.due.size()));

		$display("covered %0d sample beats and %0d reads over %0d register settings,",
			sb.n_beats, sb.n_reads, settings);
		$display("%0d buffers completed, %0d results checked, %0d mismatches",
			sb.n_complete, sb.n_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
